// File: rtl/smrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smrle_pkg
// Types and codes shared by the mask row run-length decoder.
// ----------------------------------------------------------------------------
package smrle_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COMMAND = 2'd1,
        PH_DATA    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ILLEGAL   = 3'd1,
        ST_ORDER     = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

    localparam logic [1:0] CMD_BACKGROUND = 2'b00;
    localparam logic [1:0] CMD_OPAQUE     = 2'b01;
    localparam logic [1:0] CMD_ILLEGAL    = 2'b10;
    localparam logic [1:0] CMD_END_ROW    = 2'b11;

    localparam logic       MODE_HEADER = 1'b0;
    localparam logic       KIND_SHADOW = 1'b0;

    localparam logic       REG_LAYER_KIND  = 1'b0;
    localparam logic       REG_LAYER_WIDTH = 1'b1;

    localparam logic [15:0] BLANK_MARK = 16'hFFFF;
    localparam logic [7:0]  GRAY_FULL  = 8'd255;
    localparam logic [7:0]  GRAY_ZERO  = 8'd0;

    typedef struct packed {
        logic        mode;
        logic [15:0] left_margin;
        logic [15:0] right_margin;
        logic [7:0]  stream_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [15:0] run_length;
        logic        row_end;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic        layer_kind;
        logic [15:0] layer_width;
    } layer_cfg_t;

endpackage

// File: rtl/smrle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smrle_in_if / smrle_out_if
// Valid/ready channels carrying decoder input words and run words.
// ----------------------------------------------------------------------------
interface smrle_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] left_margin;
    logic [15:0] right_margin;
    logic [7:0]  stream_byte;

    modport source (output valid, mode, left_margin, right_margin, stream_byte,
                    input ready);
    modport sink   (input valid, mode, left_margin, right_margin, stream_byte,
                    output ready);
endinterface

interface smrle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_value;
    logic [15:0] run_length;
    logic        row_end;
    logic [2:0]  status;

    modport source (output valid, pixel_value, run_length, row_end, status,
                    input ready);
    modport sink   (input valid, pixel_value, run_length, row_end, status,
                    output ready);
endinterface

// File: rtl/smrle_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smrle_step
// Row state and combinational decode of one word into at most one run.
// ----------------------------------------------------------------------------
module smrle_step
    import smrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  item_t      item,
    input  layer_cfg_t cfg,
    output logic       has_result,
    output result_t    result
);

    phase_t      phase_reg,   phase_next;
    logic [16:0] column_reg,  column_next;
    logic [15:0] right_reg,   right_next;
    logic [6:0]  bytes_reg,   bytes_next;

    logic        do_run;
    logic [15:0] run_req;
    logic [7:0]  run_value;
    logic [16:0] col_base;
    logic [15:0] room;
    logic [15:0] run_cut;
    logic [7:0]  bg;
    logic [1:0]  code;
    logic [15:0] count;
    logic [17:0] sum;
    logic        mismatch;

    assign bg    = (cfg.layer_kind == KIND_SHADOW) ? GRAY_FULL : GRAY_ZERO;
    assign code  = item.stream_byte[1:0];
    assign count = {10'd0, item.stream_byte[7:2]} + 16'd1;
    assign sum   = {1'b0, column_reg} + {2'b00, right_reg};
    // shadow layers also tolerate one pixel of slack
    assign mismatch = (sum != {2'b00, cfg.layer_width})
                   && (cfg.layer_kind || (sum + 18'd1 != {2'b00, cfg.layer_width}));

    // header runs start at column zero
    assign col_base = (item.mode == MODE_HEADER) ? 17'd0 : column_reg;
    assign room     = (col_base >= {1'b0, cfg.layer_width})
                    ? 16'd0 : cfg.layer_width - col_base[15:0];
    assign run_cut  = (run_req > room) ? room : run_req;

    always_comb
    begin
        phase_next  = phase_reg;
        column_next = column_reg;
        right_next  = right_reg;
        bytes_next  = bytes_reg;
        do_run      = 1'b0;
        run_req     = 16'd0;
        run_value   = bg;
        has_result  = 1'b1;
        result      = '{pixel_value: bg, run_length: 16'd0, row_end: 1'b0,
                        status: ST_OK};

        if (item.mode == MODE_HEADER)
        begin
            if (phase_reg != PH_HEADER)
                result.status = ST_ORDER;
            else if (item.left_margin == BLANK_MARK || item.right_margin == BLANK_MARK)
            begin
                result.run_length = cfg.layer_width;
                result.row_end    = 1'b1;
            end
            else
            begin
                right_next = item.right_margin;
                phase_next = PH_COMMAND;
                do_run     = 1'b1;
                run_req    = item.left_margin;
            end
        end
        else if (phase_reg == PH_DATA)
        begin
            do_run     = 1'b1;
            run_req    = 16'd1;
            run_value  = GRAY_FULL - item.stream_byte;
            bytes_next = bytes_reg - 7'd1;
            if (bytes_next == 7'd0)
                phase_next = PH_COMMAND;
        end
        else if (phase_reg != PH_COMMAND)
            result.status = ST_ORDER;
        else
        begin
            case (code)
                CMD_BACKGROUND:
                begin
                    do_run  = 1'b1;
                    run_req = count;
                end
                CMD_OPAQUE:
                begin
                    if (cfg.layer_kind != KIND_SHADOW)
                    begin
                        do_run    = 1'b1;
                        run_req   = count;
                        run_value = GRAY_FULL;
                    end
                    else
                    begin
                        has_result = 1'b0;
                        bytes_next = count[6:0];
                        phase_next = PH_DATA;
                    end
                end
                CMD_END_ROW:
                begin
                    result.run_length = room;
                    result.row_end    = 1'b1;
                    result.status     = mismatch ? ST_MISMATCH : ST_OK;
                    phase_next        = PH_HEADER;
                    column_next       = 17'd0;
                end
                default:
                begin
                    result.status = ST_ILLEGAL;
                    phase_next    = PH_HEADER;
                    column_next   = 17'd0;
                    bytes_next    = 7'd0;
                end
            endcase
        end

        if (do_run)
        begin
            result.pixel_value = run_value;
            result.run_length  = run_cut;
            result.status      = (run_req > room) ? ST_TRUNCATED : ST_OK;
            column_next        = col_base + {1'b0, run_cut};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            column_reg <= 17'd0;
            right_reg  <= 16'd0;
            bytes_reg  <= 7'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            column_reg <= column_next;
            right_reg  <= right_next;
            bytes_reg  <= bytes_next;
        end
    end

endmodule

// File: rtl/sprite_mask_rle_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_mask_rle_decoder
// Decodes run-length coded mask rows into runs of one gray value.
// ----------------------------------------------------------------------------
// Takes one word per clock (row header or stream byte) while the output side
// keeps up, and gives at most one run word for it. A word is held in an input
// register, decoded against the row state, and the run lands in an output
// register. The user must write layer kind and width through the config port
// only while no word is in flight; the block itself does not enforce this.
module sprite_mask_rle_decoder
    import smrle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    smrle_in_if.sink          pix_in,
    smrle_out_if.source       run_out,
    input  logic              cfg_write_en,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_wdata
);

    logic       s1_valid_reg;
    item_t      s1_item_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_word_reg;
    layer_cfg_t cfg_reg;

    logic       advance;
    logic       has_result;
    result_t    result;

    assign advance      = s1_valid_reg && (!out_valid_reg || run_out.ready);
    assign pix_in.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{layer_kind: 1'b0, layer_width: 16'd0};
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_LAYER_KIND:  cfg_reg.layer_kind  <= cfg_wdata[0];
                REG_LAYER_WIDTH: cfg_reg.layer_width <= cfg_wdata;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pix_in.ready)
            s1_valid_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_in.ready && pix_in.valid)
        begin
            s1_item_reg <= '{mode: pix_in.mode, left_margin: pix_in.left_margin,
                             right_margin: pix_in.right_margin,
                             stream_byte: pix_in.stream_byte};
        end
    end

    smrle_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .has_result (has_result),
        .result     (result)
    );

    always_comb
    begin
        if (advance && has_result)
            out_valid_next = 1'b1;
        else if (run_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
            out_word_reg <= result;
    end

    assign run_out.valid       = out_valid_reg;
    assign run_out.pixel_value = out_word_reg.pixel_value;
    assign run_out.run_length  = out_word_reg.run_length;
    assign run_out.row_end     = out_word_reg.row_end;
    assign run_out.status      = out_word_reg.status;

endmodule

// File: rtl/smrle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smrle_checker
// Port-level checks for the mask row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module smrle_checker
    import smrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  pixel_value,
    input  logic [15:0] run_length,
    input  logic        row_end,
    input  logic [2:0]  status
);

    // stalled run word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_value)
            && $stable(run_length) && $stable(row_end) && $stable(status))
        else $error("run word changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_TRUNCATED)
        else $error("status code out of range");

    // status-only words carry no pixels and never close a row
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ILLEGAL || status == ST_ORDER)
            |-> run_length == 16'd0 && !row_end)
        else $error("status-only word with pixels or row end");

    a_row_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_end |-> status == ST_OK || status == ST_MISMATCH)
        else $error("row end with unexpected status");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output register empty");

endmodule

bind sprite_mask_rle_decoder smrle_checker u_smrle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pix_in.ready),
    .out_valid   (run_out.valid),
    .out_ready   (run_out.ready),
    .pixel_value (run_out.pixel_value),
    .run_length  (run_out.run_length),
    .row_end     (run_out.row_end),
    .status      (run_out.status)
);

// File: test/sprite_mask_rle_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_mask_rle_decoder_tb
// Self-checking bench for the mask row run-length decoder. A queue of row
// headers and stream bytes feeds the input channel with random gaps while the
// output side stalls at random. Every taken word is run through a row-state
// predictor held here, and each run word that comes out is checked field by
// field against the oldest predicted run. The layer width, and mostly the kind,
// are changed between phases while the decoder is idle, including mid-row.
// ----------------------------------------------------------------------------
module sprite_mask_rle_decoder_tb;
    import smrle_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned PHASE_WORDS = 150;
    localparam int unsigned NUM_PHASES  = 10;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    smrle_in_if  pix_ch ();
    smrle_out_if run_ch ();

    sprite_mask_rle_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_in       (pix_ch),
        .run_out      (run_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    item_t       words_q[$];
    result_t     runs_due[$];
    int unsigned words_queued;
    int unsigned errors;
    int unsigned quiet_cycles;
    int unsigned in_gap;
    int unsigned out_stall;
    logic        in_taken;
    bit          in_calm;
    bit          out_calm;

    // predictor state and its copy of the layer registers
    logic        row_kind;
    int unsigned row_width;
    phase_t      row_phase;
    int unsigned row_column;
    int unsigned row_right;
    logic [6:0]  row_data_left;

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned room_in_row();
        return (row_column >= row_width) ? 0 : row_width - row_column;
    endfunction

    function automatic result_t clipped_run(logic [7:0] value, int unsigned len);
        result_t r;
        r.pixel_value = value;
        r.row_end     = 1'b0;
        r.status      = ST_OK;
        if (len > room_in_row())
        begin
            len      = room_in_row();
            r.status = ST_TRUNCATED;
        end
        row_column   = row_column + len;
        r.run_length = 16'(len);
        return r;
    endfunction

    function automatic void decode_word(input item_t w, output bit has_run,
                                        output result_t r);
        logic [7:0]  bg;
        logic [1:0]  code;
        int unsigned count;
        int unsigned total;
        bg            = (row_kind == KIND_SHADOW) ? GRAY_FULL : GRAY_ZERO;
        has_run       = 1'b1;
        r.pixel_value = bg;
        r.run_length  = 16'd0;
        r.row_end     = 1'b0;
        r.status      = ST_ORDER;
        if (w.mode == MODE_HEADER)
        begin
            if (row_phase != PH_HEADER)
                return;
            if (w.left_margin == BLANK_MARK || w.right_margin == BLANK_MARK)
            begin
                r.run_length = 16'(row_width);
                r.row_end    = 1'b1;
                r.status     = ST_OK;
                return;
            end
            row_column = 0;
            row_right  = w.right_margin;
            row_phase  = PH_COMMAND;
            r = clipped_run(bg, w.left_margin);
            return;
        end
        // awaited data bytes stay shadow data even after a layer change
        if (row_phase == PH_DATA)
        begin
            r = clipped_run(GRAY_FULL - w.stream_byte, 1);
            row_data_left = row_data_left - 7'd1;
            if (row_data_left == 7'd0)
                row_phase = PH_COMMAND;
            return;
        end
        if (row_phase != PH_COMMAND)
            return;
        code  = w.stream_byte[1:0];
        count = w.stream_byte[7:2] + 1;
        case (code)
            CMD_BACKGROUND:
                r = clipped_run(bg, count);
            CMD_OPAQUE:
            begin
                if (row_kind != KIND_SHADOW)
                    r = clipped_run(GRAY_FULL, count);
                else
                begin
                    row_data_left = 7'(count);
                    row_phase     = PH_DATA;
                    has_run       = 1'b0;
                end
            end
            CMD_END_ROW:
            begin
                total        = row_column + row_right;
                r.run_length = 16'(room_in_row());
                r.row_end    = 1'b1;
                // shadow rows tolerate one pixel of slack
                r.status = (total != row_width &&
                            (row_kind != KIND_SHADOW || total + 1 != row_width)) ?
                           ST_MISMATCH : ST_OK;
                row_phase  = PH_HEADER;
                row_column = 0;
            end
            default:
            begin
                row_phase     = PH_HEADER;
                row_column    = 0;
                row_data_left = 7'd0;
                r.status      = ST_ILLEGAL;
            end
        endcase
    endfunction

    function automatic logic [7:0] make_cmd(logic [1:0] code, int unsigned count);
        return {6'(count - 1), code};
    endfunction

    function automatic item_t header_word(int unsigned left, int unsigned right);
        item_t w;
        w.mode         = MODE_HEADER;
        w.left_margin  = 16'(left);
        w.right_margin = 16'(right);
        w.stream_byte  = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic item_t byte_word(logic [7:0] b);
        item_t w;
        w.mode         = ~MODE_HEADER;
        w.left_margin  = 16'($urandom_range(0, 65535));
        w.right_margin = 16'($urandom_range(0, 65535));
        w.stream_byte  = b;
        return w;
    endfunction

    task automatic queue_word(item_t w);
        words_q.push_back(w);
        words_queued++;
    endtask

    task automatic queue_header(int unsigned left, int unsigned right);
        queue_word(header_word(left, right));
    endtask

    task automatic queue_byte(logic [7:0] b);
        queue_word(byte_word(b));
    endtask

    // mostly well-formed rows, with some blank, broken or unfinished ones
    task automatic queue_row(bit outline, int unsigned width);
        item_t       body[$];
        int unsigned left;
        int unsigned right;
        int unsigned total;
        int unsigned count;
        int unsigned n_data;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            if ($urandom_range(0, 1))
                queue_header(BLANK_MARK, $urandom_range(0, 65535));
            else
                queue_header($urandom_range(0, 65535), BLANK_MARK);
            return;
        end
        if ($urandom_range(0, 3) != 0)
            left = $urandom_range(0, width / 4);
        else
            left = $urandom_range(0, 8);
        total = left;
        repeat ($urandom_range(0, 6))
        begin
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) :
                                                  $urandom_range(1, 8);
            if ($urandom_range(0, 1))
                body.push_back(byte_word(make_cmd(CMD_BACKGROUND, count)));
            else
            begin
                body.push_back(byte_word(make_cmd(CMD_OPAQUE, count)));
                if (!outline)
                begin
                    n_data = count;
                    if ($urandom_range(0, 19) == 0)
                        n_data = $urandom_range(0, count - 1);
                    repeat (n_data)
                        body.push_back(byte_word(8'($urandom_range(0, 255))));
                end
            end
            total += count;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
            right = (width >= total) ? width - total : $urandom_range(0, 65535);
        else if (pick < 75)
            right = (width > total) ? width - total - 1 : 0;
        else
            right = $urandom_range(0, 300);
        queue_header(left, right);
        foreach (body[i])
            queue_word(body[i]);
        pick = $urandom_range(0, 99);
        if (pick < 85)
            queue_byte(make_cmd(CMD_END_ROW, $urandom_range(1, 64)));
        else if (pick < 92)
            queue_byte(make_cmd(CMD_ILLEGAL, $urandom_range(1, 64)));
    endtask

    // wait for every word to be taken and every run to come back, then drain
    task automatic settle();
        do
            @(negedge clk);
        while (words_q.size() != 0 || pix_ch.valid || runs_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_wdata    <= 16'(value);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // input driver
    always @(negedge clk)
    begin
        item_t w;
        if (rst_n && (!pix_ch.valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap       <= in_gap - 1;
                pix_ch.valid <= 1'b0;
            end
            else if (words_q.size() > 0)
            begin
                w = words_q.pop_front();
                pix_ch.valid        <= 1'b1;
                pix_ch.mode         <= w.mode;
                pix_ch.left_margin  <= w.left_margin;
                pix_ch.right_margin <= w.right_margin;
                pix_ch.stream_byte  <= w.stream_byte;
                in_gap              <= pick_gap(in_calm);
            end
            else
                pix_ch.valid <= 1'b0;
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_stall > 0)
            begin
                run_ch.ready <= 1'b0;
                out_stall    <= out_stall - 1;
            end
            else
            begin
                run_ch.ready <= 1'b1;
                out_stall    <= pick_gap(out_calm);
            end
        end
    end

    // predictor, run checker and watchdog
    always @(posedge clk)
    begin
        item_t   w;
        result_t want;
        result_t got;
        bit      has_run;
        if (!rst_n)
        begin
            row_kind      = KIND_SHADOW;
            row_width     = 0;
            row_phase     = PH_HEADER;
            row_column    = 0;
            row_right     = 0;
            row_data_left = 7'd0;
            in_taken     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == REG_LAYER_KIND)
                    row_kind = cfg_wdata[0];
                else
                    row_width = cfg_wdata;
            end
            in_taken <= pix_ch.valid && pix_ch.ready;
            if (pix_ch.valid && pix_ch.ready)
            begin
                w.mode         = pix_ch.mode;
                w.left_margin  = pix_ch.left_margin;
                w.right_margin = pix_ch.right_margin;
                w.stream_byte  = pix_ch.stream_byte;
                decode_word(w, has_run, want);
                if (has_run)
                    runs_due.push_back(want);
            end
            if (run_ch.valid && run_ch.ready)
            begin
                got.pixel_value = run_ch.pixel_value;
                got.run_length  = run_ch.run_length;
                got.row_end     = run_ch.row_end;
                got.status      = run_ch.status;
                if (runs_due.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("unexpected run word: value %0d len %0d end %0d status %0d",
                                 got.pixel_value, got.run_length, got.row_end, got.status);
                    errors++;
                end
                else
                begin
                    want = runs_due.pop_front();
                    if (got.pixel_value !== want.pixel_value ||
                        got.run_length !== want.run_length ||
                        got.row_end !== want.row_end || got.status !== want.status)
                    begin
                        if (errors < MAX_REPORTS)
                            $display({"run mismatch: expected value %0d len %0d end %0d",
                                      " status %0d, got value %0d len %0d end %0d status %0d"},
                                     want.pixel_value, want.run_length, want.row_end,
                                     want.status, got.pixel_value, got.run_length,
                                     got.row_end, got.status);
                        errors++;
                    end
                end
            end
            if ((pix_ch.valid && pix_ch.ready) || (run_ch.valid && run_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("sprite_mask_rle_decoder_tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned width;
        bit          kind;
        int unsigned pick;
        pix_ch.valid        = 1'b0;
        pix_ch.mode         = MODE_HEADER;
        pix_ch.left_margin  = 16'd0;
        pix_ch.right_margin = 16'd0;
        pix_ch.stream_byte  = 8'd0;
        run_ch.ready        = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_index           = REG_LAYER_KIND;
        cfg_wdata           = 16'd0;
        errors              = 0;
        quiet_cycles        = 0;
        words_queued        = 0;
        in_gap              = 0;
        out_stall           = 0;
        in_calm             = 1'b0;
        out_calm            = 1'b0;
        rst_n               = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: shadow layer, 40 pixels
        write_reg(REG_LAYER_KIND, KIND_SHADOW);
        write_reg(REG_LAYER_WIDTH, 40);
        queue_byte(8'h00);                              // byte with no row open
        queue_header(BLANK_MARK, 7);
        queue_header(7, BLANK_MARK);
        queue_header(3, 4);
        queue_byte(make_cmd(CMD_BACKGROUND, 2));
        queue_byte(make_cmd(CMD_OPAQUE, 3));
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h5A);
        queue_header(1, 1);                             // header inside a row
        queue_byte(make_cmd(CMD_BACKGROUND, 64));       // cut short
        queue_byte(make_cmd(CMD_OPAQUE, 2));
        queue_byte(8'h11);                              // data with no room
        queue_byte(8'h22);
        queue_byte(make_cmd(CMD_END_ROW, 1));           // margins do not add up
        queue_header(0, 0);                             // empty left run
        queue_byte(make_cmd(CMD_BACKGROUND, 39));
        queue_byte(make_cmd(CMD_END_ROW, 64));          // one pixel of slack
        queue_header(10, 30);
        queue_byte(make_cmd(CMD_END_ROW, 1));
        queue_header(1, 1);
        queue_byte(make_cmd(CMD_ILLEGAL, 1));
        queue_byte(make_cmd(CMD_BACKGROUND, 17));
        queue_header(65534, 0);
        queue_byte(make_cmd(CMD_END_ROW, 64));
        settle();

        // directed: outline layer, no slack allowed
        write_reg(REG_LAYER_KIND, ~KIND_SHADOW);
        queue_header(2, 5);
        queue_byte(make_cmd(CMD_OPAQUE, 4));
        queue_byte(make_cmd(CMD_END_ROW, 1));
        queue_header(0, 0);
        queue_byte(make_cmd(CMD_OPAQUE, 39));
        queue_byte(make_cmd(CMD_END_ROW, 1));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0: width = 0;
                1: width = 65535;
                2: width = 1;
                default:
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        width = $urandom_range(1, 120);
                    else if (pick < 80)
                        width = $urandom_range(121, 2000);
                    else
                        width = $urandom_range(0, 65535);
                end
            endcase
            kind = (ph < 2) ? ph[0] : $urandom_range(0, 1);
            // sometimes only the width moves, possibly mid-row
            if (ph < 3 || $urandom_range(0, 3) != 0)
                write_reg(REG_LAYER_KIND, kind);
            else
                kind = row_kind;
            write_reg(REG_LAYER_WIDTH, width);
            in_calm      = ($urandom_range(0, 3) == 0);
            out_calm     = ($urandom_range(0, 3) == 0);
            words_queued = 0;
            while (words_queued < PHASE_WORDS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    queue_header($urandom_range(0, 65535), $urandom_range(0, 65535));
                else if (pick < 9)
                    queue_byte(8'($urandom_range(0, 255)));
                else
                    queue_row(kind, width);
            end
        end

        settle();
        repeat (8) @(negedge clk);
        if (runs_due.size() != 0)
            errors++;
        if (errors == 0)
            $display("sprite_mask_rle_decoder_tb passed");
        else
            $display("sprite_mask_rle_decoder_tb failed");
        $finish;
    end

endmodule

// File: sprite_mask_rle_decoder.f
rtl/smrle_pkg.sv
rtl/smrle_if.sv
rtl/smrle_step.sv
rtl/sprite_mask_rle_decoder.sv
rtl/smrle_checker.sv
test/sprite_mask_rle_decoder_tb.sv
